// ===== rtl/phx_pkg.sv =====
// ----------------------------------------------------------------------------
// Philox 4x32 package
// Shared widths, round constants, register indexes and cell types.
// ----------------------------------------------------------------------------
package phx_pkg;

    localparam int PHX_ROUND_COUNT = 10;
    localparam int WORD_W          = 32;
    localparam int PROD_W          = 2 * WORD_W;
    localparam int CFG_IDX_W       = 2;

    localparam logic [WORD_W-1:0] PHX_MUL_A  = 32'hD251_1F53;
    localparam logic [WORD_W-1:0] PHX_MUL_B  = 32'hCD9E_8D57;
    localparam logic [WORD_W-1:0] PHX_WEYL_A = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] PHX_WEYL_B = 32'hBB67_AE85;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_HIGH = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] x0;
        logic [WORD_W-1:0] x1;
        logic [WORD_W-1:0] x2;
        logic [WORD_W-1:0] x3;
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
    } phx_state_t;

    typedef struct packed {
        logic [PROD_W-1:0] pa;
        logic [PROD_W-1:0] pb;
        logic [WORD_W-1:0] x1;
        logic [WORD_W-1:0] x3;
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
    } phx_prod_t;

endpackage

// ===== rtl/phx_cell.sv =====
// ----------------------------------------------------------------------------
// Philox round cell
// One round: register both widening products, then mix with key into the
// state handed to the next cell, along with the bumped key.
// ----------------------------------------------------------------------------
module phx_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  phx_pkg::phx_state_t in_state,
    output logic               out_valid,
    output phx_pkg::phx_state_t out_state
);
    import phx_pkg::*;

    logic      valid_reg;
    phx_prod_t prod_reg;
    phx_prod_t prod_next;

    always_comb
    begin
        prod_next.pa = PROD_W'(in_state.x0) * PROD_W'(PHX_MUL_A);
        prod_next.pb = PROD_W'(in_state.x2) * PROD_W'(PHX_MUL_B);
        prod_next.x1 = in_state.x1;
        prod_next.x3 = in_state.x3;
        prod_next.k0 = in_state.k0;
        prod_next.k1 = in_state.k1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        out_state.x0 = prod_reg.pb[PROD_W-1:WORD_W] ^ prod_reg.x1 ^ prod_reg.k0;
        out_state.x1 = prod_reg.pb[WORD_W-1:0];
        out_state.x2 = prod_reg.pa[PROD_W-1:WORD_W] ^ prod_reg.x3 ^ prod_reg.k1;
        out_state.x3 = prod_reg.pa[WORD_W-1:0];
        out_state.k0 = prod_reg.k0 + PHX_WEYL_A;
        out_state.k1 = prod_reg.k1 + PHX_WEYL_B;
    end

    assign out_valid = valid_reg;

endmodule

// ===== rtl/philox_4x32_counter_rng_top.sv =====
// Path: each index passes the register of every round cell, then the output register.
// Throughput: one index per cycle; the chain of round cells advances as a
// whole and stalls only while the output register holds an untaken result.
// Reset: clears all valid bits and the key and stream registers to zero.
// ----------------------------------------------------------------------------
// Philox 4x32 counter RNG top
// Config registers, chain of round cells and the output register.
// ----------------------------------------------------------------------------
module philox_4x32_counter_rng_top #(
    parameter int ROUND_COUNT = phx_pkg::PHX_ROUND_COUNT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [phx_pkg::WORD_W-1:0]     s_tdata,   // element_index
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [4*phx_pkg::WORD_W-1:0]   m_tdata,   // word_zero, word_one,
                                                      // word_two, word_three
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [phx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phx_pkg::WORD_W-1:0]     cfg_data
);
    import phx_pkg::*;

    logic [WORD_W-1:0]   key_low_reg;
    logic [WORD_W-1:0]   key_high_reg;
    logic [WORD_W-1:0]   stream_low_reg;
    logic [WORD_W-1:0]   stream_high_reg;
    logic                adv;
    logic [ROUND_COUNT:0] chain_valid;
    phx_state_t          chain_state [ROUND_COUNT+1];
    logic                out_valid_reg;
    logic [4*WORD_W-1:0] out_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg     <= '0;
            key_high_reg    <= '0;
            stream_low_reg  <= '0;
            stream_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:     key_low_reg     <= cfg_data;
                CFG_KEY_HIGH:    key_high_reg    <= cfg_data;
                CFG_STREAM_LOW:  stream_low_reg  <= cfg_data;
                CFG_STREAM_HIGH: stream_high_reg <= cfg_data;
                default:         key_low_reg     <= key_low_reg;
            endcase
        end
    end

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    assign chain_valid[0]    = s_tvalid;
    assign chain_state[0].x0 = s_tdata;
    assign chain_state[0].x1 = stream_low_reg;
    assign chain_state[0].x2 = stream_high_reg;
    assign chain_state[0].x3 = '0;
    assign chain_state[0].k0 = key_low_reg;
    assign chain_state[0].k1 = key_high_reg;

    for (genvar i = 0; i < ROUND_COUNT; i++)
    begin : g_round
        phx_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (chain_valid[i]),
            .in_state  (chain_state[i]),
            .out_valid (chain_valid[i+1]),
            .out_state (chain_state[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= chain_valid[ROUND_COUNT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {chain_state[ROUND_COUNT].x3, chain_state[ROUND_COUNT].x2,
                             chain_state[ROUND_COUNT].x1, chain_state[ROUND_COUNT].x0};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && chain_valid[ROUND_COUNT]) |=> m_tvalid)
        else $error("finished round result not moved to output register");

    a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(chain_valid[ROUND_COUNT:1]))
        else $error("round chain moved during stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> chain_valid[1])
        else $error("accepted transaction did not enter first cell");

    a_cfg_key: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == CFG_KEY_LOW)
        |=> key_low_reg == $past(cfg_data))
        else $error("key write lost");

endmodule

// ===== tb/sv/philox_4x32_counter_rng_top_tb.sv =====
// ----------------------------------------------------------------------------
// Philox 4x32 counter RNG testbench
// Streams element indexes through the generator under several key and
// stream settings, predicts the four output words of each index with a
// local Philox model and checks every result in order, with random idle
// cycles on the input side and random back-pressure on the output side.
// ----------------------------------------------------------------------------
module philox_4x32_counter_rng_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import phx_pkg::*;

    localparam int DRAIN_CYCLES = PHX_ROUND_COUNT + 4;

    class rng_word_checker;
        logic [WORD_W-1:0]   key_lo;
        logic [WORD_W-1:0]   key_hi;
        logic [WORD_W-1:0]   stream_lo;
        logic [WORD_W-1:0]   stream_hi;
        logic [4*WORD_W-1:0] expected_words[$];
        int                  mismatches;
        int                  results_checked;
        int                  indexes_sent;

        function new();
            key_lo          = '0;
            key_hi          = '0;
            stream_lo       = '0;
            stream_hi       = '0;
            mismatches      = 0;
            results_checked = 0;
            indexes_sent    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
            case (idx)
                CFG_KEY_LOW:     key_lo    = value;
                CFG_KEY_HIGH:    key_hi    = value;
                CFG_STREAM_LOW:  stream_lo = value;
                CFG_STREAM_HIGH: stream_hi = value;
                default: ;
            endcase
        endfunction

        function logic [4*WORD_W-1:0] philox_words(logic [WORD_W-1:0] element_index);
            logic [WORD_W-1:0] c0, c1, c2, c3, k0, k1;
            logic [PROD_W-1:0] prod_a, prod_b;
            c0 = element_index;
            c1 = stream_lo;
            c2 = stream_hi;
            c3 = '0;
            k0 = key_lo;
            k1 = key_hi;
            for (int r = 0; r < PHX_ROUND_COUNT; r++)
            begin
                prod_a = PROD_W'(PHX_MUL_A) * PROD_W'(c0);
                prod_b = PROD_W'(PHX_MUL_B) * PROD_W'(c2);
                c0 = prod_b[PROD_W-1:WORD_W] ^ c1 ^ k0;
                c1 = prod_b[WORD_W-1:0];
                c2 = prod_a[PROD_W-1:WORD_W] ^ c3 ^ k1;
                c3 = prod_a[WORD_W-1:0];
                k0 = k0 + PHX_WEYL_A;
                k1 = k1 + PHX_WEYL_B;
            end
            return {c3, c2, c1, c0};
        endfunction

        function void note_index(logic [WORD_W-1:0] element_index);
            expected_words.push_back(philox_words(element_index));
            indexes_sent++;
        endfunction

        function void check_words(logic [4*WORD_W-1:0] actual);
            logic [4*WORD_W-1:0] want;
            bit                  bad;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", actual);
                return;
            end
            want = expected_words.pop_front();
            results_checked++;
            bad = 1'b0;
            for (int f = 0; f < 4; f++)
                if (actual[f*WORD_W +: WORD_W] !== want[f*WORD_W +: WORD_W])
                    bad = 1'b1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d words 0..3 expected %h %h %h %h got %h %h %h %h",
                             results_checked,
                             want[31:0], want[63:32], want[95:64], want[127:96],
                             actual[31:0], actual[63:32], actual[95:64], actual[127:96]);
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata   = '0;  // element_index
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [4*WORD_W-1:0]   m_tdata;         // word_zero, word_one, word_two, word_three
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0]     cfg_data  = '0;

    rng_word_checker chk = new();
    bit              quiet = 1'b0;
    int              settings_used = 0;

    philox_4x32_counter_rng_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WORD_W-1:0] rand_index();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom();
        if (r == 7)
            return $urandom_range(0, 15);
        if (r == 8)
            return 32'hFFFF_FFFF - $urandom_range(0, 15);
        return 32'h1 << $urandom_range(0, 31);
    endfunction

    function automatic logic [WORD_W-1:0] rand_reg_value();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    task automatic send_index(input logic [WORD_W-1:0] element_index);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= element_index;
        do
            @(posedge clk);
        while (!s_tready);
        chk.note_index(element_index);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        while (chk.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        chk.set_reg(idx, value);
    endtask

    task automatic program_regs(input logic [WORD_W-1:0] k_lo, input logic [WORD_W-1:0] k_hi,
                                input logic [WORD_W-1:0] st_lo, input logic [WORD_W-1:0] st_hi);
        write_reg(CFG_KEY_LOW, k_lo);
        write_reg(CFG_KEY_HIGH, k_hi);
        write_reg(CFG_STREAM_LOW, st_lo);
        write_reg(CFG_STREAM_HIGH, st_hi);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int count, input bit hold_midway);
        for (int n = 0; n < count; n++)
        begin
            if (hold_midway && n == count / 2)
            begin
                s_tvalid <= 1'b0;
                drain();
            end
            send_index(rand_index());
        end
        s_tvalid <= 1'b0;
    endtask

    // check results and apply random back-pressure
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                chk.check_words(m_tdata);
            if (stall == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [WORD_W-1:0] corner_list[7];
        corner_list = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: all keys and stream words zero
        settings_used++;
        foreach (corner_list[i])
            send_index(corner_list[i]);
        s_tvalid <= 1'b0;
        drain();

        program_regs('1, '1, '1, '1);
        foreach (corner_list[i])
            send_index(corner_list[i]);
        s_tvalid <= 1'b0;
        drain();

        for (int p = 0; p < 6; p++)
        begin
            if (p == 0)
                program_regs('0, '1, '0, '1);
            else
                program_regs(rand_reg_value(), rand_reg_value(),
                             rand_reg_value(), rand_reg_value());
            quiet = (p == 2);
            run_random(82, p == 3);
            drain();
        end
        quiet = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d element indexes under %0d key/stream settings, %0d results checked,",
                 chk.indexes_sent, settings_used, chk.results_checked);
        $display("%0d mismatching or unexpected results.", chk.mismatches);
        if (chk.mismatches == 0 && chk.pending() == 0)
            $display("philox_4x32_counter_rng_top_tb passed");
        else
            $display("philox_4x32_counter_rng_top_tb failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("philox_4x32_counter_rng_top_tb failed");
        $finish;
    end

endmodule
